// File: rtl/wsp_pkg.sv
// Shared widths, constants and helper functions for the world-to-screen projection.
// No dependencies; every other file in rtl imports this package.
`default_nettype none
package wsp_pkg;

  localparam int NREGS     = 8;
  localparam int CFG_IDX_W = 8;
  localparam int CLIP_W    = 50;
  localparam int SUM_W     = 51;
  localparam int NUM_W     = 81;
  localparam int DEN_W     = 50;
  localparam int Q_W       = 33;
  localparam int DIV_STEPS = 33;
  localparam int LO_W      = 26;
  localparam int HI_W      = SUM_W - LO_W;
  localparam int K_W       = 15;

  localparam logic [63:0] REG_RESET [NREGS] = '{
    64'h0000_0001_0000_0000, 64'h0, 64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000
  };

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic              mode;
    logic              err;
    logic              cx_neg;
    logic              cy_neg;
    logic              cz_neg;
    logic              neg_x;
    logic              neg_y;
    logic              neg_z;
    logic signed [31:0] dz_raw;
  } side_t;

  function automatic logic [SUM_W-1:0] mag51(input logic signed [SUM_W-1:0] v);
    mag51 = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  function automatic logic signed [31:0] sat_clip(input logic signed [CLIP_W-1:0] v);
    if (v > CLIP_W'(S32_MAX)) sat_clip = S32_MAX;
    else if (v < CLIP_W'(S32_MIN)) sat_clip = S32_MIN;
    else sat_clip = v[31:0];
  endfunction

  // Applies the sign to a quotient magnitude and clamps it to 32 bits.
  function automatic logic signed [31:0] sat_quot(input logic [Q_W-1:0] q,
                                                  input logic ovf, input logic neg);
    if (neg) begin
      if (ovf || q > Q_W'(33'h0_8000_0000)) sat_quot = S32_MIN;
      else sat_quot = 32'(-q);
    end else begin
      if (ovf || q[Q_W-1] || q[31]) sat_quot = S32_MAX;
      else sat_quot = q[31:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/wsp_if.sv
// Handshake channels of the projection block: vertex requests, results, register writes.
// Depends on wsp_pkg for the register index width.
`default_nettype none
interface wsp_vertex_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [31:0] world_z;
  logic              mode;
  modport source (output valid, world_x, world_y, world_z, mode, input ready);
  modport sink (input valid, world_x, world_y, world_z, mode, output ready);
endinterface

interface wsp_result_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] depth_out;
  logic              divide_error;
  modport source (output valid, screen_x, screen_y, depth_out, divide_error, input ready);
  modport sink (input valid, screen_x, screen_y, depth_out, divide_error, output ready);
endinterface

interface wsp_cfg_if;
  import wsp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/wsp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Depends on wsp_pkg for widths.
`default_nettype none
module wsp_div_pipe (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [wsp_pkg::NUM_W-1:0]  num,
  input  wire logic [wsp_pkg::DEN_W-1:0]  den,
  output logic      [wsp_pkg::Q_W-1:0]    q,
  output logic                            ovf
);
  import wsp_pkg::*;

  logic [DEN_W:0]     rem  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] low [DIV_STEPS+1];
  logic [Q_W-1:0]     quo  [DIV_STEPS+1];
  logic [DEN_W-1:0]   dv   [DIV_STEPS+1];
  logic               of   [DIV_STEPS+1];

  // The quotient fits 33 bits only when the top part of the numerator is below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      of[0]   <= (DEN_W+1)'(num[NUM_W-1:DIV_STEPS]) >= (DEN_W+1)'(den);
      rem[0]  <= (DEN_W+1)'(num[NUM_W-1:DIV_STEPS]);
      low[0]  <= num[DIV_STEPS-1:0];
      quo[0]  <= '0;
      dv[0]   <= den;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DEN_W+1:0] t;
    logic             take;
    assign t    = {rem[k-1], low[k-1][DIV_STEPS-1]};
    assign take = t >= (DEN_W+2)'(dv[k-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? (DEN_W+1)'(t - (DEN_W+2)'(dv[k-1])) : (DEN_W+1)'(t);
        low[k] <= low[k-1] << 1;
        quo[k] <= {quo[k-1][Q_W-2:0], take};
        dv[k]  <= dv[k-1];
        of[k]  <= of[k-1];
      end
    end
  end

  assign q   = quo[DIV_STEPS];
  assign ovf = of[DIV_STEPS];
endmodule
`default_nettype wire

// File: rtl/world_to_screen_projection.sv
// World-to-screen projection: 4x4 matrix transform, perspective divide, viewport map.
// Accepts one request per cycle while the output register is not held by backpressure.
// The 33 one-bit divider stages set the depth; the whole pipe stalls on output backpressure.
// Reset clears the valid bits and loads the matrix registers with their default values.
// Depends on wsp_pkg, wsp_if and wsp_div_pipe.
`default_nettype none
module world_to_screen_projection #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst,
  wsp_vertex_if.sink    vertex,
  wsp_result_if.source  result,
  wsp_cfg_if.sink       cfg
);
  import wsp_pkg::*;

  localparam logic [K_W-1:0] W_K = K_W'(SCREEN_WIDTH);
  localparam logic [K_W-1:0] H_K = K_W'(SCREEN_HEIGHT);
  // Four front stages, the divider input register, the divider steps and the output register.
  localparam int PIPE_STAGES = 5 + DIV_STEPS + 1;

  // Matrix registers. Writes beyond the register list are dropped.
  logic [63:0] regs [NREGS];
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREGS; i++) regs[i] <= REG_RESET[i];
    end else if (cfg.valid && cfg.index < CFG_IDX_W'(NREGS)) begin
      regs[cfg.index[2:0]] <= cfg.data;
    end
  end

  logic signed [31:0] mat [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      mat[r][0] = regs[2*r][63:32];
      mat[r][1] = regs[2*r][31:0];
      mat[r][2] = regs[2*r+1][63:32];
      mat[r][3] = regs[2*r+1][31:0];
    end
  end

  // The whole pipe moves together; it holds only when the result register is full
  // and the consumer is not taking it.
  logic en;
  logic [PIPE_STAGES-1:0] vld;
  assign en = !result.valid || result.ready;
  assign vertex.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_STAGES-2:0], vertex.valid};
    end
  end
  assign result.valid = vld[PIPE_STAGES-1];

  // Stage 1: twelve 32x32 products; the w=1 column is a plain shift later.
  logic signed [63:0] prod [4][3];
  logic signed [31:0] m3   [4];
  logic               s1_mode;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= mat[r][0] * vertex.world_x;
        prod[r][1] <= mat[r][1] * vertex.world_y;
        prod[r][2] <= mat[r][2] * vertex.world_z;
        m3[r]      <= mat[r][3];
      end
      s1_mode <= vertex.mode;
    end
  end

  // Stage 2: exact row sums, floored back to Q34.16 clip coordinates.
  logic signed [CLIP_W-1:0] clip [4];
  logic                     s2_mode;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        logic signed [65:0] acc;
        acc = 66'(prod[r][0]) + 66'(prod[r][1]) + 66'(prod[r][2]) + (66'(m3[r]) <<< 16);
        clip[r] <= acc[65:16];
      end
      s2_mode <= s1_mode;
    end
  end

  // Stage 3: viewport numerators as magnitudes, split in halves for the pixel-scale multiply.
  logic signed [SUM_W-1:0] ax, ay;
  logic [SUM_W-1:0]        max_c, may_c, maz_c;
  assign ax    = SUM_W'(clip[0]) + SUM_W'(clip[3]);
  assign ay    = SUM_W'(clip[3]) - SUM_W'(clip[1]);
  assign max_c = mag51(ax);
  assign may_c = mag51(ay);
  assign maz_c = mag51(SUM_W'(clip[2]));

  logic [LO_W+K_W-1:0] plo_x, plo_y;
  logic [HI_W+K_W-1:0] phi_x, phi_y;
  logic [SUM_W-1:0]    s3_mz;
  logic [DEN_W-1:0]    s3_den;
  side_t               s3_side;
  always_ff @(posedge clk) begin
    if (en) begin
      plo_x  <= (LO_W+K_W)'(max_c[LO_W-1:0]) * (LO_W+K_W)'(W_K);
      phi_x  <= (HI_W+K_W)'(max_c[SUM_W-1:LO_W]) * (HI_W+K_W)'(W_K);
      plo_y  <= (LO_W+K_W)'(may_c[LO_W-1:0]) * (LO_W+K_W)'(H_K);
      phi_y  <= (HI_W+K_W)'(may_c[SUM_W-1:LO_W]) * (HI_W+K_W)'(H_K);
      s3_mz  <= maz_c;
      s3_den <= DEN_W'(mag51(SUM_W'(clip[3])));
      s3_side.mode   <= s2_mode;
      s3_side.err    <= clip[3] == '0;
      s3_side.cx_neg <= clip[0][CLIP_W-1];
      s3_side.cy_neg <= clip[1][CLIP_W-1];
      s3_side.cz_neg <= clip[2][CLIP_W-1];
      s3_side.neg_x  <= ax[SUM_W-1] ^ clip[3][CLIP_W-1];
      s3_side.neg_y  <= ay[SUM_W-1] ^ clip[3][CLIP_W-1];
      s3_side.neg_z  <= clip[2][CLIP_W-1] ^ clip[3][CLIP_W-1];
      s3_side.dz_raw <= sat_clip(clip[2]);
    end
  end

  // Stage 4: combine halves and apply the 2^15 (x, y) and 2^16 (depth) scale.
  logic [NUM_W-1:0] num_x, num_y, num_z;
  logic [DEN_W-1:0] s4_den;
  side_t            s4_side;
  always_ff @(posedge clk) begin
    if (en) begin
      num_x   <= ((NUM_W'(phi_x) << LO_W) + NUM_W'(plo_x)) << 15;
      num_y   <= ((NUM_W'(phi_y) << LO_W) + NUM_W'(plo_y)) << 15;
      num_z   <= NUM_W'(s3_mz) << 16;
      s4_den  <= s3_den;
      s4_side <= s3_side;
    end
  end

  // Three dividers in lockstep; the side information travels beside them.
  logic [Q_W-1:0] qx, qy, qz;
  logic           ox, oy, oz;
  wsp_div_pipe u_div_x (.clk, .en, .num(num_x), .den(s4_den), .q(qx), .ovf(ox));
  wsp_div_pipe u_div_y (.clk, .en, .num(num_y), .den(s4_den), .q(qy), .ovf(oy));
  wsp_div_pipe u_div_z (.clk, .en, .num(num_z), .den(s4_den), .q(qz), .ovf(oz));

  side_t side [DIV_STEPS+1];
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= s4_side;
      for (int k = 1; k <= DIV_STEPS; k++) side[k] <= side[k-1];
    end
  end

  // Output register: sign, saturation, the zero-w case and the depth mode select.
  side_t sd;
  assign sd = side[DIV_STEPS];
  always_ff @(posedge clk) begin
    if (en) begin
      result.divide_error <= sd.err;
      if (sd.err) begin
        result.screen_x  <= sd.cx_neg ? S32_MIN : S32_MAX;
        result.screen_y  <= sd.cy_neg ? S32_MAX : S32_MIN;
      end else begin
        result.screen_x  <= sat_quot(qx, ox, sd.neg_x);
        result.screen_y  <= sat_quot(qy, oy, sd.neg_y);
      end
      // Raw depth ignores w entirely, so it wins over the zero-w saturation.
      if (sd.mode) begin
        result.depth_out <= sd.dz_raw;
      end else if (sd.err) begin
        result.depth_out <= sd.cz_neg ? S32_MIN : S32_MAX;
      end else begin
        result.depth_out <= sat_quot(qz, oz, sd.neg_z);
      end
    end
  end
endmodule
`default_nettype wire
